// ===== rtl/core/gfs_pkg.sv =====
// Shared types and constants for the Gaussian FIR smoother.
// No dependencies; every module of the block imports this package.
package gfs_pkg;

   localparam int MAX_HALF    = 6;
   localparam int SAMPLE_BITS = 16;
   localparam int COEF_BITS   = 16;
   localparam int DEPTH       = 2 * MAX_HALF + 1;
   localparam int HALF_BITS   = $clog2(MAX_HALF + 1);
   localparam int STEP_BITS   = $clog2(MAX_HALF + 2);
   localparam int IDX_BITS    = $clog2(DEPTH);
   localparam int COUNT_BITS  = 4;
   localparam int COUNT_MAX   = 15;
   localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int PAIR_BITS   = SAMPLE_BITS + 1;
   localparam int PROD_BITS   = COEF_BITS + 1 + PAIR_BITS;
   localparam int ACC_BITS    = PROD_BITS + 3;
   localparam int FRAC_BITS   = COEF_BITS - 1;
   localparam int PART_A      = (MAX_HALF + 2) / 2;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;

   // register map
   localparam logic [CSR_INDEX_BITS-1:0] REG_HALF_WIDTH  = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_CENTER = 4'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_SIX    = 4'd7;

   localparam logic [COEF_BITS-1:0] COEF_CENTER_RESET = COEF_BITS'(1) << (COEF_BITS - 1);

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef sample_type [DEPTH-1:0]         window_type;   // index 0 is newest
   typedef logic [COEF_BITS-1:0]           coef_type;
   typedef coef_type [MAX_HALF:0]          coef_set_type;
   typedef logic signed [PROD_BITS-1:0]    prod_type;
   typedef logic signed [ACC_BITS-1:0]     acc_type;

   // one queued item: the window after the shift plus what it has to produce
   typedef struct packed {
      window_type           window;
      logic [HALF_BITS-1:0] half;
      logic                 emit_main;
      logic                 main_filt;
      logic [HALF_BITS-1:0] flush_n;
      logic                 last;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== rtl/core/gfs_front.sv =====
// Front end: accepts samples, keeps the delay line and the sample count, and
// turns each item with a result into a queue job. Depends on gfs_pkg.
module gfs_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [gfs_pkg::TDATA_BITS-1:0]      req_tdata,   // [15:0] sample_in
   input  logic                                req_tlast,
   input  logic [gfs_pkg::HALF_BITS-1:0]       cfg_half,
   input  logic                                q_ready,
   output logic                                push,
   output gfs_pkg::job_type                    push_job
);
   import gfs_pkg::*;

   window_type            delay_ff, delay_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [HALF_BITS-1:0]  half;
   logic [COUNT_BITS-1:0] twice_half;
   logic                  accept;
   logic                  have_main;
   sample_type            sample;

   always_comb begin
      half       = (cfg_half > HALF_BITS'(MAX_HALF)) ? HALF_BITS'(MAX_HALF) : cfg_half;
      twice_half = COUNT_BITS'(half) << 1;
      accept     = req_tvalid && q_ready;
      sample     = $signed(req_tdata[SAMPLE_BITS-1:0]);
      delay_in   = {delay_ff[DEPTH-2:0], sample};
      have_main  = count_ff >= COUNT_BITS'(half);

      push_job.window    = delay_in;
      push_job.half      = half;
      push_job.emit_main = have_main;
      push_job.main_filt = count_ff >= twice_half;
      push_job.last      = req_tlast;
      // last item: flush what is pending; in a short sequence everything seen so far comes out raw
      if (!req_tlast)
         push_job.flush_n = '0;
      else if (have_main)
         push_job.flush_n = half;
      else
         push_job.flush_n = HALF_BITS'(count_ff + COUNT_BITS'(1));

      push = accept && (have_main || req_tlast);

      if (req_tlast)
         count_in = '0;
      else if (count_ff == COUNT_BITS'(COUNT_MAX))
         count_in = count_ff;
      else
         count_in = count_ff + COUNT_BITS'(1);
   end

   assign req_tready = q_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         delay_ff <= delay_in;
      end
   end

endmodule

// ===== rtl/core/gfs_queue.sv =====
// Two-entry job queue between front and back end.
// Depends on gfs_pkg.
module gfs_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  gfs_pkg::job_type           push_job,
   input  logic                       pop,
   output gfs_pkg::job_type           head_job,
   output gfs_pkg::queue_status_type  status
);
   import gfs_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
      status.full  = fill_ff == 2'd2;
      status.empty = fill_ff == 2'd0;
      head_job     = entry_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/core/gfs_back.sv =====
// Back end: expands each job into its results, runs the filter pipeline
// (taps, two adder levels, round and saturate) and holds the output register.
// Depends on gfs_pkg.
module gfs_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            head_valid,
   input  gfs_pkg::job_type                head_job,
   output logic                            pop,
   input  gfs_pkg::coef_set_type           coefs,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [gfs_pkg::TDATA_BITS-1:0]  rsp_tdata,   // [15:0] sample_out
   output logic                            rsp_tlast
);
   import gfs_pkg::*;

   // sequencer
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [STEP_BITS-1:0] total, flush_pos;
   logic [IDX_BITS-1:0]  raw_idx;
   logic                 advance, issue, last_step, is_main;

   // stage 0: selected result
   logic                 s0_valid_ff, s0_filt_ff, s0_last_ff;
   sample_type           s0_raw_ff;
   window_type           s0_window_ff;
   logic [HALF_BITS-1:0] s0_half_ff;

   // stage 1: tap products
   logic                 s1_valid_ff, s1_filt_ff, s1_last_ff;
   sample_type           s1_raw_ff;
   prod_type             prod_in [MAX_HALF+1];
   prod_type             prod_ff [MAX_HALF+1];

   // stage 2: partial sums
   logic                 s2_valid_ff, s2_filt_ff, s2_last_ff;
   sample_type           s2_raw_ff;
   acc_type              part_a_in, part_b_in, part_a_ff, part_b_ff;

   // stage 3: full sum
   logic                 s3_valid_ff, s3_filt_ff, s3_last_ff;
   sample_type           s3_raw_ff;
   acc_type              acc_ff;

   // output register
   logic                 out_valid_ff, out_last_ff;
   sample_type           out_data_ff, out_data_in;

   logic signed [ACC_BITS-FRAC_BITS-1:0] rounded;
   logic                                 all_same;

   // sequencer: main result first, then the flushed samples oldest first
   always_comb begin
      advance   = !out_valid_ff || rsp_tready;
      issue     = head_valid && advance;
      total     = STEP_BITS'(head_job.emit_main) + STEP_BITS'(head_job.flush_n);
      last_step = step_ff == (total - STEP_BITS'(1));
      pop       = issue && last_step;
      is_main   = head_job.emit_main && (step_ff == '0);
      flush_pos = step_ff - STEP_BITS'(head_job.emit_main);
      if (is_main)
         raw_idx = IDX_BITS'(head_job.half);
      else
         raw_idx = IDX_BITS'(head_job.flush_n) - IDX_BITS'(1) - IDX_BITS'(flush_pos);
      if (pop)
         step_in = '0;
      else if (issue)
         step_in = step_ff + STEP_BITS'(1);
      else
         step_in = step_ff;
   end

   // taps: pair samples symmetric around the center, zero beyond h
   always_comb begin
      logic signed [PAIR_BITS-1:0] pair;
      logic signed [COEF_BITS:0]   coef_s;
      logic [IDX_BITS-1:0]         idx_hi, idx_lo;
      for (int d = 0; d <= MAX_HALF; d++) begin
         idx_hi = IDX_BITS'(s0_half_ff) + IDX_BITS'(d);
         idx_lo = (HALF_BITS'(d) <= s0_half_ff) ?
                  IDX_BITS'(s0_half_ff) - IDX_BITS'(d) : '0;
         if (d == 0)
            pair = PAIR_BITS'(s0_window_ff[idx_lo]);
         else if (HALF_BITS'(d) <= s0_half_ff)
            pair = PAIR_BITS'(s0_window_ff[idx_hi]) + PAIR_BITS'(s0_window_ff[idx_lo]);
         else
            pair = '0;
         coef_s     = $signed({1'b0, coefs[d]});
         prod_in[d] = coef_s * pair;
      end
   end

   always_comb begin
      part_a_in = '0;
      part_b_in = '0;
      for (int d = 0; d <= MAX_HALF; d++) begin
         if (d < PART_A)
            part_a_in = part_a_in + ACC_BITS'(prod_ff[d]);
         else
            part_b_in = part_b_in + ACC_BITS'(prod_ff[d]);
      end
   end

   // round half up, then saturate to the sample range; raw results pass as they are
   always_comb begin
      acc_type biased;
      biased   = acc_ff + (ACC_BITS'(1) <<< (FRAC_BITS - 1));
      rounded  = biased[ACC_BITS-1:FRAC_BITS];
      all_same = (rounded[ACC_BITS-FRAC_BITS-1:SAMPLE_BITS-1] == '0) ||
                 (rounded[ACC_BITS-FRAC_BITS-1:SAMPLE_BITS-1] == '1);
      if (!s3_filt_ff)
         out_data_in = s3_raw_ff;
      else if (all_same)
         out_data_in = rounded[SAMPLE_BITS-1:0];
      else if (rounded[ACC_BITS-FRAC_BITS-1])
         out_data_in = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      else
         out_data_in = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (advance) begin
            s0_valid_ff  <= issue;
            s1_valid_ff  <= s0_valid_ff;
            s2_valid_ff  <= s1_valid_ff;
            s3_valid_ff  <= s2_valid_ff;
            out_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_filt_ff   <= is_main && head_job.main_filt;
         s0_last_ff   <= head_job.last && last_step;
         s0_raw_ff    <= head_job.window[raw_idx];
         s0_window_ff <= head_job.window;
         s0_half_ff   <= head_job.half;

         s1_filt_ff <= s0_filt_ff;
         s1_last_ff <= s0_last_ff;
         s1_raw_ff  <= s0_raw_ff;
         for (int d = 0; d <= MAX_HALF; d++) begin
            prod_ff[d] <= prod_in[d];
         end

         s2_filt_ff <= s1_filt_ff;
         s2_last_ff <= s1_last_ff;
         s2_raw_ff  <= s1_raw_ff;
         part_a_ff  <= part_a_in;
         part_b_ff  <= part_b_in;

         s3_filt_ff <= s2_filt_ff;
         s3_last_ff <= s2_last_ff;
         s3_raw_ff  <= s2_raw_ff;
         acc_ff     <= part_a_ff + part_b_ff;

         out_last_ff <= s3_last_ff;
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = TDATA_BITS'($unsigned(out_data_ff));

endmodule

// ===== rtl/core/gaussian_fir_smoother.sv =====
// Top level of the Gaussian FIR smoother: register file, front end, job
// queue and back end. Depends on gfs_pkg, gfs_front, gfs_queue, gfs_back.
//
//   channel  direction  ports                      content
//   req      in         req_tvalid/tready/tdata    sample_in, tlast = last_in
//   rsp      out        rsp_tvalid/tready/tdata    sample_out, tlast = last_out
//   csr      in         csr_valid/ready/index/data register writes, always ready
//
// An item that is not last is accepted every cycle and gives at most one
// result; a last item gives up to h+1 results, one per cycle from the back
// end's sequencer. Results pass the select, taps, two adder levels and
// round/saturate registers. Reset is synchronous and clears counts, pointers
// and valid bits. A stalled rsp channel holds the whole back pipeline; the
// two-entry queue keeps req going until it fills.
module gaussian_fir_smoother (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [gfs_pkg::TDATA_BITS-1:0]       req_tdata,   // [15:0] sample_in
   input  logic                                 req_tlast,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [gfs_pkg::TDATA_BITS-1:0]       rsp_tdata,   // [15:0] sample_out
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gfs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [gfs_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import gfs_pkg::*;

   logic [HALF_BITS-1:0]  half_ff;
   coef_set_type          coef_ff;
   logic [HALF_BITS-1:0]  coef_sel;
   logic                  push, pop;
   job_type               push_job, head_job;
   queue_status_type      q_stat;

   assign csr_ready = 1'b1;
   assign coef_sel  = HALF_BITS'(csr_index - REG_COEF_CENTER);

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff <= '0;
         coef_ff <= {{(MAX_HALF*COEF_BITS){1'b0}}, COEF_CENTER_RESET};
      end else if (csr_valid) begin
         unique case (csr_index) inside
            REG_HALF_WIDTH: begin
               half_ff <= csr_data[HALF_BITS-1:0];
            end
            [REG_COEF_CENTER:REG_COEF_SIX]: begin
               coef_ff[coef_sel] <= csr_data[COEF_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   gfs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cfg_half   (half_ff),
      .q_ready    (!q_stat.full),
      .push       (push),
      .push_job   (push_job)
   );

   gfs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_stat)
   );

   gfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!q_stat.empty),
      .head_job   (head_job),
      .pop        (pop),
      .coefs      (coef_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full)
      else $error("job pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("job popped from an empty queue");

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue both full and empty");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed");
`endif

endmodule

// ===== sim/tb_gaussian_fir_smoother.sv =====
// Self-checking bench for gaussian_fir_smoother: a scoreboard-style smoothing
// predictor fed by directed and random sample streams. Depends on gfs_pkg and the RTL.
module tb_gaussian_fir_smoother;
   import gfs_pkg::*;

   localparam int SETTLE_CYCLES = 2 * MAX_HALF + 12;
   localparam int IDLE_LIMIT    = 3000;
   localparam int HOLD_CYCLES   = 200;
   localparam int REPORT_MAX    = 10;

   localparam sample_type SAMPLE_MAX = 16'sh7fff;
   localparam sample_type SAMPLE_MIN = 16'sh8000;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED_FIRST = REG_COEF_SIX + 1'b1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED_TOP   = '1;

   typedef struct {
      sample_type value;
      logic       last;
   } smoothed_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [TDATA_BITS-1:0]     req_tdata = '0;      // [15:0] sample_in
   logic                      req_tlast = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [TDATA_BITS-1:0]     rsp_tdata;           // [15:0] sample_out
   logic                      rsp_tlast;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   gaussian_fir_smoother dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [HALF_BITS-1:0]  half_reg;
   coef_type              weight [MAX_HALF+1];
   sample_type            hist [DEPTH];        // index 0 is newest
   logic [COUNT_BITS-1:0] seq_count;
   smoothed_type          smoothed_q [$];

   int mismatches = 0;
   int samples_sent = 0;
   int results_checked = 0;
   int reg_writes = 0;
   int input_stall_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int idle_cycles = 0;

   logic hold_trigger = 1'b0;
   logic hold_seen = 1'b0;
   int   hold_left = 0;

   function automatic void clear_model();
      half_reg = '0;
      weight[0] = COEF_CENTER_RESET;
      for (int k = 1; k <= MAX_HALF; k++) weight[k] = '0;
      for (int k = 0; k < DEPTH; k++) hist[k] = '0;
      seq_count = '0;
   endfunction

   function automatic void apply_reg(logic [CSR_INDEX_BITS-1:0] index,
                                     logic [CSR_DATA_BITS-1:0] value);
      if (index == REG_HALF_WIDTH)
         half_reg = value[HALF_BITS-1:0];
      else if (index >= REG_COEF_CENTER && index <= REG_COEF_SIX)
         weight[index - REG_COEF_CENTER] = value[COEF_BITS-1:0];
   endfunction

   // symmetric taps around hist[h], round half up, saturate
   function automatic sample_type filter_at(int h);
      longint acc;
      longint pair;
      longint rounded;
      acc = longint'(weight[0]) * longint'(hist[h]);
      for (int d = 1; d <= h; d++) begin
         pair = longint'(hist[h + d]) + longint'(hist[h - d]);
         acc += longint'(weight[d]) * pair;
      end
      rounded = (acc + 64'sd16384) >>> 15;
      if (rounded > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
      if (rounded < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
      return sample_type'(rounded);
   endfunction

   function automatic void smooth_step(sample_type s, logic l);
      int h;
      int i;
      int first;
      int n;
      sample_type vals [MAX_HALF+1];
      smoothed_type res;
      h = (half_reg > MAX_HALF) ? MAX_HALF : int'(half_reg);
      i = int'(seq_count);
      n = 0;
      for (int d = DEPTH - 1; d > 0; d--) hist[d] = hist[d - 1];
      hist[0] = s;
      if (i >= h) begin
         vals[n] = (i >= 2 * h) ? filter_at(h) : hist[h];
         n++;
      end
      if (l) begin
         // flush whatever is still pending in the window
         first = (i >= h) ? h - 1 : i;
         for (int d = first; d >= 0; d--) begin
            vals[n] = hist[d];
            n++;
         end
         seq_count = '0;
      end else begin
         seq_count = (i >= COUNT_MAX) ? COUNT_BITS'(COUNT_MAX) : COUNT_BITS'(i + 1);
      end
      for (int k = 0; k < n; k++) begin
         res.value = vals[k];
         res.last  = l && (k == n - 1);
         smoothed_q = {smoothed_q, res};
      end
   endfunction

   function automatic void check_result(sample_type got, logic got_last);
      smoothed_type want;
      if (smoothed_q.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("unexpected result: sample %0d last %0b", got, got_last);
         return;
      end
      want = smoothed_q.pop_front();
      results_checked++;
      if (got !== want.value || got_last !== want.last) begin
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("mismatch at result %0d: expected sample %0d last %0b, got %0d last %0b",
                     results_checked, want.value, want.last, got, got_last);
      end
   endfunction

   // accepts on all channels are observed here, in one place
   always @(posedge clock) begin
      if (reset) begin
         clear_model();
      end else begin
         if (csr_valid && csr_ready) begin
            apply_reg(csr_index, csr_data);
            reg_writes++;
         end
         if (req_tvalid && req_tready) begin
            smooth_step(sample_type'(req_tdata[SAMPLE_BITS-1:0]), req_tlast);
            samples_sent++;
         end
         if (req_tvalid && !req_tready) input_stall_cycles++;
         if (rsp_tvalid && rsp_tready)
            check_result(sample_type'(rsp_tdata[SAMPLE_BITS-1:0]), rsp_tlast);
      end
   end

   // receiver: random stalls, plus a long hold each time hold_trigger toggles
   always @(posedge clock) begin
      if (hold_trigger != hold_seen) begin
         hold_seen  <= hold_trigger;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
         $display("tb_gaussian_fir_smoother failed");
         $finish;
      end
   end

   task automatic send_sample(input sample_type s, input logic l);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= TDATA_BITS'($urandom);
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= TDATA_BITS'(s);
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
   endtask

   // leaves csr_valid high; the caller lowers it after its last write
   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (smoothed_q.size() != 0) @(posedge clock);
      // items that give no result may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_weights(input logic [CSR_DATA_BITS-1:0] half,
                              input coef_type w);
      write_reg(REG_HALF_WIDTH, half);
      for (int k = 0; k <= MAX_HALF; k++)
         write_reg(CSR_INDEX_BITS'(REG_COEF_CENTER + k), w);
      csr_valid <= 1'b0;
   endtask

   function automatic coef_type pick_weight();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return '1;
         2, 3:    return coef_type'($urandom_range(0, 12000));
         default: return coef_type'($urandom);
      endcase
   endfunction

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 11))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return '0;
         3:       return '1;
         default: return sample_type'($urandom);
      endcase
   endfunction

   // fixed_half < 0 picks the width at random; upper data bits are junk
   task automatic random_config(input int fixed_half);
      logic [CSR_DATA_BITS-1:0] word;
      word = CSR_DATA_BITS'($urandom);
      word[HALF_BITS-1:0] = (fixed_half < 0) ? HALF_BITS'($urandom_range(0, 7))
                                             : HALF_BITS'(fixed_half);
      write_reg(REG_HALF_WIDTH, word);
      for (int k = 0; k <= MAX_HALF; k++)
         write_reg(CSR_INDEX_BITS'(REG_COEF_CENTER + k), pick_weight());
      if ($urandom_range(0, 2) == 0)
         write_reg(REG_UNUSED_FIRST + CSR_INDEX_BITS'($urandom_range(0, 7)),
                   CSR_DATA_BITS'($urandom));
      csr_valid <= 1'b0;
   endtask

   // whole sequences with random content; the phase may stop mid-sequence
   task automatic send_sequences(input int total);
      int done;
      int len;
      done = 0;
      while (done < total) begin
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(14, 20)
                                            : $urandom_range(1, 13);
         for (int k = 0; k < len && done < total; k++) begin
            send_sample(pick_sample(), k == len - 1);
            done++;
         end
      end
   endtask

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct <= recv_pct;
   endtask

   task automatic test_passthrough_defaults();
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample('1, 1'b1);
      wait_drained();
   endtask

   task automatic test_saturation();
      // widest filter, width register above the limit, all weights full scale
      set_weights(CSR_DATA_BITS'(7), '1);
      for (int k = 0; k < DEPTH; k++) send_sample(SAMPLE_MIN, k == DEPTH - 1);
      wait_drained();
      set_weights(CSR_DATA_BITS'(1), '1);
      for (int k = 0; k < 3; k++) send_sample(SAMPLE_MAX, k == 2);
      wait_drained();
   endtask

   task automatic test_short_sequence();
      set_weights(CSR_DATA_BITS'(3), coef_type'(8192));
      send_sample(sample_type'(1234), 1'b0);
      send_sample(sample_type'(-4321), 1'b1);
      wait_drained();
      write_reg(REG_HALF_WIDTH, CSR_DATA_BITS'(4));
      csr_valid <= 1'b0;
      send_sample(sample_type'(77), 1'b1);
      wait_drained();
   endtask

   task automatic test_width_change_midstream();
      set_weights(CSR_DATA_BITS'(2), coef_type'(6000));
      for (int k = 0; k < 3; k++) send_sample(pick_sample(), 1'b0);
      wait_drained();
      write_reg(REG_HALF_WIDTH, CSR_DATA_BITS'(5));
      write_reg(REG_UNUSED_TOP, '1);
      csr_valid <= 1'b0;
      for (int k = 0; k < 3; k++) send_sample(pick_sample(), k == 2);
      wait_drained();
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct);
      set_idling(send_pct, recv_pct);
      for (int phase = 0; phase < 3; phase++) begin
         random_config(phase == 0 ? 0 : (phase == 1 ? MAX_HALF : -1));
         send_sequences(25);
         wait_drained();
      end
   endtask

   task automatic test_backpressure();
      set_idling(0, 0);
      random_config(MAX_HALF);
      hold_trigger <= ~hold_trigger;
      send_sequences(30);
      wait_drained();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_passthrough_defaults();
      test_saturation();
      test_short_sequence();
      test_width_change_midstream();
      test_random_traffic(9, 52);
      test_random_traffic(52, 9);
      test_random_traffic(0, 0);
      test_backpressure();
      wait_drained();
      $display("covered %0d samples, %0d results checked, %0d register writes",
               samples_sent, results_checked, reg_writes);
      $display("input stalled %0d cycles; widths 0..7, full-scale weights, flushes",
               input_stall_cycles);
      if (mismatches == 0 && smoothed_q.size() == 0)
         $display("tb_gaussian_fir_smoother passed");
      else
         $display("tb_gaussian_fir_smoother failed");
      $finish;
   end

endmodule
